// ===== design/frwl_pkg.sv =====
// Shared types and constants for the flow rule wildcard lookup.
// Holds the rule entry and key structs, opcodes, status codes and key builder.
// No dependencies.
package frwl_pkg;

    localparam int EP_W     = 48;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 3;
    localparam int TRY_W    = 2;

    // operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_ADD    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

    // lookup tries
    localparam logic [TRY_W-1:0] TRY_EXACT    = 2'd0;
    localparam logic [TRY_W-1:0] TRY_BOTH_ANY = 2'd3;

    typedef struct packed {
        logic [EP_W-1:0] ep1;
        logic [EP_W-1:0] ep2;
    } key_t;

    typedef struct packed {
        logic                vld;
        logic [EP_W-1:0]     ep1;
        logic [EP_W-1:0]     ep2;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // Endpoint = {addr, port}; swap into canonical order when symmetric.
    function automatic key_t make_key(input logic [ADDR_W-1:0] sa,
                                      input logic [PORT_W-1:0] sp,
                                      input logic [ADDR_W-1:0] da,
                                      input logic [PORT_W-1:0] dp,
                                      input logic              sym);
        key_t k;
        logic [EP_W-1:0] a;
        logic [EP_W-1:0] b;
        a = {sa, sp};
        b = {da, dp};
        if (sym && (b < a)) begin
            k.ep1 = b;
            k.ep2 = a;
        end else begin
            k.ep1 = a;
            k.ep2 = b;
        end
        return k;
    endfunction

endpackage

// ===== design/flow_rule_wildcard_lookup.sv =====
// Top level of the flow rule table with port wildcard lookup.
// Builds keys, drives the chain of frwl_cell entries, reduces hits, holds the result.
// Depends on frwl_pkg and frwl_cell.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  s_      | in        | s_tvalid / s_tready    | tuser: operation; tdata: key+handle
//  m_      | out       | m_tvalid / m_tready    | tuser: status; tdata: rule, try
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_data: symmetric_keys
//
// Flow: a beat is taken, then one key try per cycle is built and compared against
// every cell at once; the first hitting try (or the last) loads the result register.
// An add makes only the exact try; a lookup makes up to four tries. The next beat is taken
// the cycle after the result loads, so only one item is in flight at a time.
// Reset: synchronous, active low; cell valid bits clear at once, no clearing pass.
// No beat is taken on either input channel while reset is held.
// Stalls: the result register is held while m_tready is low; the try pipe
// freezes only when a finished result cannot enter the full result register.
module flow_rule_wildcard_lookup #(
    parameter int RULE_ENTRIES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // src_addr[31:0], src_port[47:32], dst_addr[79:48],
                                    // dst_port[95:80], rule_in[103:96]
    input  logic [0:0]   s_tuser,   // operation[0]
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // rule_out[7:0], match_try[9:8], zero[15:10]
    output logic [2:0]   m_tuser,   // status[2:0]
    // configuration
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data   // symmetric_keys
);

    // Input beat fields
    logic                            s_op;
    logic [frwl_pkg::ADDR_W-1:0]     s_sa;
    logic [frwl_pkg::PORT_W-1:0]     s_sp;
    logic [frwl_pkg::ADDR_W-1:0]     s_da;
    logic [frwl_pkg::PORT_W-1:0]     s_dp;
    logic [frwl_pkg::HANDLE_W-1:0]   s_rule;

    assign s_op   = s_tuser[0];
    assign s_sa   = s_tdata[31:0];
    assign s_sp   = s_tdata[47:32];
    assign s_da   = s_tdata[79:48];
    assign s_dp   = s_tdata[95:80];
    assign s_rule = s_tdata[103:96];

    // Latched item
    logic                            sym_reg;
    logic                            busy_reg;
    logic                            op_reg;
    logic [frwl_pkg::ADDR_W-1:0]     sa_reg;
    logic [frwl_pkg::PORT_W-1:0]     sp_reg;
    logic [frwl_pkg::ADDR_W-1:0]     da_reg;
    logic [frwl_pkg::PORT_W-1:0]     dp_reg;
    logic [frwl_pkg::HANDLE_W-1:0]   rule_reg;

    // Try pipe: issue counter, then the key under compare
    logic [frwl_pkg::TRY_W:0]        issue_reg;
    logic                            kv_reg;
    logic [frwl_pkg::TRY_W-1:0]      kt_reg;
    frwl_pkg::key_t                  key_reg;

    // Result register
    logic                            out_valid_reg;
    logic [frwl_pkg::STATUS_W-1:0]   status_reg;
    logic [frwl_pkg::HANDLE_W-1:0]   rule_out_reg;
    logic [frwl_pkg::TRY_W-1:0]      try_out_reg;

    // Chain
    frwl_pkg::entry_t                ent [RULE_ENTRIES];
    frwl_pkg::entry_t                head_entry;
    logic [RULE_ENTRIES-1:0]         hit_vec;
    logic [RULE_ENTRIES-1:0]         vld_vec;

    logic                            any_hit;
    logic [frwl_pkg::HANDLE_W-1:0]   hit_handle;
    logic                            table_full;
    logic [frwl_pkg::TRY_W-1:0]      last_try;
    logic                            issue_more;
    logic [frwl_pkg::TRY_W-1:0]      try_no;
    logic [frwl_pkg::PORT_W-1:0]     try_sp;
    logic [frwl_pkg::PORT_W-1:0]     try_dp;
    logic                            final_try;
    logic                            fire;
    logic                            advance;
    logic                            insert;
    logic                            s_fire;

    assign s_tready  = aresetn && !busy_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = aresetn;

    // An add makes only the exact try; a lookup walks the four in order until one hits.
    assign last_try   = (op_reg == frwl_pkg::OP_ADD) ? frwl_pkg::TRY_EXACT
                                                     : frwl_pkg::TRY_BOTH_ANY;
    assign issue_more = (issue_reg <= {1'b0, last_try});
    assign try_no     = issue_reg[frwl_pkg::TRY_W-1:0];
    // try bit 0 wilds the source port, bit 1 the destination port
    assign try_sp     = try_no[0] ? '0 : sp_reg;
    assign try_dp     = try_no[1] ? '0 : dp_reg;

    // Hit reduction: keys are unique in the table, so at most one cell hits.
    always_comb begin
        any_hit    = |hit_vec;
        hit_handle = '0;
        for (int i = 0; i < RULE_ENTRIES; i++) begin
            hit_handle = hit_handle | ({frwl_pkg::HANDLE_W{hit_vec[i]}} & ent[i].handle);
        end
    end

    assign table_full = vld_vec[RULE_ENTRIES-1];
    assign final_try  = kv_reg && (any_hit || (kt_reg == last_try));
    assign fire       = busy_reg && final_try && (!out_valid_reg || m_tready);
    assign advance    = busy_reg && !(final_try && !fire);
    assign insert     = fire && (op_reg == frwl_pkg::OP_ADD) && !any_hit && !table_full;

    // New entry enters at the head of the chain.
    assign head_entry.vld    = 1'b1;
    assign head_entry.ep1    = key_reg.ep1;
    assign head_entry.ep2    = key_reg.ep2;
    assign head_entry.handle = rule_reg;

    for (genvar g = 0; g < RULE_ENTRIES; g++) begin : g_cell
        frwl_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (insert),
            .prev_in   ((g == 0) ? head_entry : ent[(g == 0) ? 0 : g - 1]),
            .key       (key_reg),
            .entry_out (ent[g]),
            .hit       (hit_vec[g])
        );
        assign vld_vec[g] = ent[g].vld;
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            sym_reg <= cfg_data;
        end
    end

    // Item latch
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg   <= s_op;
            sa_reg   <= s_sa;
            sp_reg   <= s_sp;
            da_reg   <= s_da;
            dp_reg   <= s_dp;
            rule_reg <= s_rule;
        end
    end

    // Control: busy flag and try pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            kv_reg    <= 1'b0;
            issue_reg <= '0;
            kt_reg    <= '0;
        end else if (s_fire) begin
            busy_reg  <= 1'b1;
            kv_reg    <= 1'b0;
            issue_reg <= '0;
        end else if (fire) begin
            busy_reg  <= 1'b0;
            kv_reg    <= 1'b0;
        end else if (advance) begin
            kv_reg    <= issue_more;
            kt_reg    <= try_no;
            if (issue_more) begin
                issue_reg <= issue_reg + 1'b1;
            end
        end
    end

    // Key register; held while a finished result waits for the result register.
    always_ff @(posedge aclk) begin
        if (advance && !fire && issue_more) begin
            key_reg <= frwl_pkg::make_key(sa_reg, try_sp, da_reg, try_dp, sym_reg);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            if (op_reg == frwl_pkg::OP_ADD) begin
                rule_out_reg <= '0;
                try_out_reg  <= '0;
                if (any_hit) begin
                    status_reg <= frwl_pkg::ST_DUP;
                end else if (table_full) begin
                    status_reg <= frwl_pkg::ST_FULL;
                end else begin
                    status_reg <= frwl_pkg::ST_ADDED;
                end
            end else if (any_hit) begin
                status_reg   <= frwl_pkg::ST_HIT;
                rule_out_reg <= hit_handle;
                try_out_reg  <= kt_reg;
            end else begin
                status_reg   <= frwl_pkg::ST_MISS;
                rule_out_reg <= '0;
                try_out_reg  <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'd0, try_out_reg, rule_out_reg};

    // Valid cells always form a prefix of the chain.
    a_vld_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((vld_vec >> 1) & ~vld_vec) == '0)
        else $error("valid cells not a prefix of the chain");

    // Stored keys are unique, so one key hits at most one cell.
    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        kv_reg |-> $onehot0(hit_vec))
        else $error("key hit more than one cell");

    // An insert adds exactly one valid cell.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        insert |=> ($countones(vld_vec) == $past($countones(vld_vec)) + 1))
        else $error("insert did not add one entry");

    // A result only loads out of a busy item.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(busy_reg))
        else $error("result without an item in flight");

endmodule

// ===== design/frwl_cell.sv =====
// One rule cell of the lookup chain: holds one entry, compares it to the key.
// On insert every cell takes its upstream neighbor's entry.
// Depends on frwl_pkg.
module frwl_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  frwl_pkg::entry_t  prev_in,
    input  frwl_pkg::key_t    key,
    output frwl_pkg::entry_t  entry_out,
    output logic              hit
);

    logic                          vld_reg;
    logic [frwl_pkg::EP_W-1:0]     ep1_reg;
    logic [frwl_pkg::EP_W-1:0]     ep2_reg;
    logic [frwl_pkg::HANDLE_W-1:0] handle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (shift_en) begin
            vld_reg <= prev_in.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            ep1_reg    <= prev_in.ep1;
            ep2_reg    <= prev_in.ep2;
            handle_reg <= prev_in.handle;
        end
    end

    assign entry_out.vld    = vld_reg;
    assign entry_out.ep1    = ep1_reg;
    assign entry_out.ep2    = ep2_reg;
    assign entry_out.handle = handle_reg;

    assign hit = vld_reg && (ep1_reg == key.ep1) && (ep2_reg == key.ep2);

endmodule

// ===== tb/sv/frwl_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the flow rule wildcard lookup bench: its own rule table and
// symmetric-key setting, the queue of expected answers, and the result checks.
// Depends on frwl_pkg.
package frwl_tb_pkg;
    import frwl_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int TRY_COUNT   = 4;
    localparam int MAX_PRINTED = 40;

    // middle tries are not named in the design package
    localparam logic [TRY_W-1:0] TRY_ANY_SRC = 2'd1;
    localparam logic [TRY_W-1:0] TRY_ANY_DST = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [TRY_W-1:0]    which_try;
    } rule_answer_t;

    class flow_table_scoreboard;
        entry_t       rules[TABLE_DEPTH];
        logic         symmetric;
        rule_answer_t answer_q[$];
        int           errors;
        int           checked;
        int           status_seen[8];
        int           try_hits[TRY_COUNT];

        function new();
            symmetric = 1'b1;
            errors    = 0;
            checked   = 0;
            foreach (rules[i]) rules[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
            foreach (try_hits[i]) try_hits[i] = 0;
        endfunction

        function void set_symmetric(input logic value);
            symmetric = value;
        endfunction

        function int pending();
            return answer_q.size();
        endfunction

        function int rules_held();
            int n;
            n = 0;
            foreach (rules[i]) if (rules[i].vld) n++;
            return n;
        endfunction

        // endpoint = {addr, port}; lesser endpoint first when symmetric
        function key_t endpoint_pair(input logic [ADDR_W-1:0] sa, input logic [PORT_W-1:0] sp,
                                     input logic [ADDR_W-1:0] da, input logic [PORT_W-1:0] dp);
            logic [EP_W-1:0] near_ep;
            logic [EP_W-1:0] far_ep;
            key_t            k;
            near_ep = {sa, sp};
            far_ep  = {da, dp};
            if (symmetric && (far_ep < near_ep)) begin
                k.ep1 = far_ep;
                k.ep2 = near_ep;
            end else begin
                k.ep1 = near_ep;
                k.ep2 = far_ep;
            end
            return k;
        endfunction

        function int find_slot(input key_t k);
            foreach (rules[i])
                if (rules[i].vld && rules[i].ep1 == k.ep1 && rules[i].ep2 == k.ep2) return i;
            return -1;
        endfunction

        function int free_slot();
            foreach (rules[i]) if (!rules[i].vld) return i;
            return -1;
        endfunction

        // update the table for one accepted request and queue its answer
        function void note_request(input logic op,
                                   input logic [ADDR_W-1:0] sa, input logic [PORT_W-1:0] sp,
                                   input logic [ADDR_W-1:0] da, input logic [PORT_W-1:0] dp,
                                   input logic [HANDLE_W-1:0] handle);
            rule_answer_t      ans;
            key_t              k;
            int                slot;
            logic [PORT_W-1:0] try_sp;
            logic [PORT_W-1:0] try_dp;
            logic [TRY_W-1:0]  tr;
            logic              found;
            ans.status    = ST_MISS;
            ans.handle    = '0;
            ans.which_try = TRY_EXACT;
            if (op == OP_ADD) begin
                k = endpoint_pair(sa, sp, da, dp);
                if (find_slot(k) >= 0) begin
                    ans.status = ST_DUP;
                end else begin
                    slot = free_slot();
                    if (slot < 0) begin
                        ans.status = ST_FULL;
                    end else begin
                        rules[slot].vld    = 1'b1;
                        rules[slot].ep1    = k.ep1;
                        rules[slot].ep2    = k.ep2;
                        rules[slot].handle = handle;
                        ans.status         = ST_ADDED;
                    end
                end
            end else begin
                found = 1'b0;
                for (int n = 0; n < TRY_COUNT; n++) begin
                    tr     = TRY_W'(n);
                    try_sp = (tr == TRY_ANY_SRC || tr == TRY_BOTH_ANY) ? '0 : sp;
                    try_dp = (tr == TRY_ANY_DST || tr == TRY_BOTH_ANY) ? '0 : dp;
                    slot   = find_slot(endpoint_pair(sa, try_sp, da, try_dp));
                    if (!found && slot >= 0) begin
                        found         = 1'b1;
                        ans.status    = ST_HIT;
                        ans.handle    = rules[slot].handle;
                        ans.which_try = tr;
                    end
                end
            end
            answer_q.insert(answer_q.size(), ans);
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("mismatch at answer %0d: %s", checked, msg);
        endtask

        task check_answer(input logic [STATUS_W-1:0] status, input logic [HANDLE_W-1:0] handle,
                          input logic [TRY_W-1:0] which_try);
            rule_answer_t want;
            if (answer_q.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending, status %0d", status));
                return;
            end
            want = answer_q[0];
            answer_q.delete(0);
            checked++;
            status_seen[want.status]++;
            if (want.status == ST_HIT) try_hits[want.which_try]++;
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", status, want.status));
            if (handle !== want.handle)
                report_mismatch($sformatf("rule_out %0h, want %0h", handle, want.handle));
            if (which_try !== want.which_try)
                report_mismatch($sformatf("match_try %0d, want %0d", which_try, want.which_try));
        endtask
    endclass

endpackage

// ===== tb/sv/flow_rule_wildcard_lookup_tb.sv =====
`timescale 1ns / 100ps
// Top of the flow rule wildcard lookup bench: clock, reset, request/result/config
// drivers, directed and random phases, the watchdog and the final verdict.
// Depends on frwl_pkg, frwl_tb_pkg and the flow_rule_wildcard_lookup RTL.
module flow_rule_wildcard_lookup_tb;
    import frwl_pkg::*;
    import frwl_tb_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int IDLE_LIMIT       = 1000;
    localparam int RANDOM_PER_PHASE = 120;
    localparam int HOLD_AT_ANSWER   = 150;
    localparam int HOLD_CYCLES      = 120;
    localparam int SETTLE_CYCLES    = 8;

    localparam logic [ADDR_W-1:0] A_ADDR = 32'h0A00_0001;
    localparam logic [ADDR_W-1:0] B_ADDR = 32'h0A00_0002;
    localparam logic [ADDR_W-1:0] C_ADDR = 32'hC0A8_0001;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
    localparam logic [PORT_W-1:0] PORT_MAX = '1;

    typedef struct {
        logic [ADDR_W-1:0] sa;
        logic [PORT_W-1:0] sp;
        logic [ADDR_W-1:0] da;
        logic [PORT_W-1:0] dp;
    } flow_key_t;

    // every block input known from time zero
    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic [103:0] s_tdata   = '0;
    logic [0:0]   s_tuser   = '0;
    logic         m_tready  = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_data  = 1'b0;
    wire          s_tready;
    wire          m_tvalid;
    wire  [15:0]  m_tdata;
    wire  [2:0]   m_tuser;
    wire          cfg_ready;

    flow_table_scoreboard table_board;
    flow_key_t            rule_pool[$];   // keys offered as adds, reused for hits
    logic [ADDR_W-1:0]    addr_pool[8];   // small address set so rules overlap
    logic [PORT_W-1:0]    port_pool[4];
    int                   sent_beats     = 0;
    int                   answered_beats = 0;
    int                   sym_writes     = 0;
    int                   idle_cycles    = 0;
    logic                 hold_done      = 1'b0;

    flow_rule_wildcard_lookup #(
        .RULE_ENTRIES (TABLE_DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // src_addr, src_port, dst_addr, dst_port, rule_in (low first)
        .s_tuser   (s_tuser),   // operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // rule_out[7:0], match_try[9:8], zero pad above
        .m_tuser   (m_tuser),   // status
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d answers outstanding",
                         IDLE_LIMIT, table_board.pending());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Request driver. Called at a falling edge; returns at the falling edge
    // after the beat was taken, with tvalid still up so a zero gap chains beats.
    // Every 64 beats the first 16 go back to back.
    task automatic send_request(input logic op, input flow_key_t f,
                                input logic [HANDLE_W-1:0] handle);
        int gap;
        gap = (sent_beats % 64 < 16) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = {handle, f.dp, f.da, f.sp, f.sa};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        table_board.note_request(op, f.sa, f.sp, f.da, f.dp, handle);
        sent_beats++;
        @(negedge aclk);
    endtask

    // Drop the request side and wait until every answer is back, plus a margin.
    task automatic drain_and_settle();
        s_tvalid = 1'b0;
        while (table_board.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_symmetric(input logic value);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        table_board.set_symmetric(value);
        sym_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // wildcard, well-known or fully random port
    function automatic logic [PORT_W-1:0] pick_port();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return port_pool[$urandom_range(0, 3)];
            default: return PORT_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic flow_key_t fresh_flow();
        flow_key_t f;
        f.sa = $urandom_range(0, 1) ? addr_pool[$urandom_range(0, 7)] : ADDR_W'($urandom());
        f.da = $urandom_range(0, 1) ? addr_pool[$urandom_range(0, 7)] : ADDR_W'($urandom());
        f.sp = pick_port();
        f.dp = pick_port();
        return f;
    endfunction

    // Mostly adds of new keys and lookups built from stored keys: wildcard
    // ports filled in, one port disturbed, direction flipped. The rest is
    // re-adds (duplicates) and requests with unrelated keys.
    task automatic run_random_phase(input int count);
        flow_key_t         f;
        logic              op;
        logic [ADDR_W-1:0] tmp_addr;
        logic [PORT_W-1:0] tmp_port;
        repeat (count) begin
            op = ($urandom_range(0, 99) < 35) ? OP_ADD : OP_LOOKUP;
            if (op == OP_ADD && (rule_pool.size() == 0 || $urandom_range(0, 9) < 6)) begin
                f = fresh_flow();
                rule_pool.insert(rule_pool.size(), f);
            end else if (rule_pool.size() != 0 && $urandom_range(0, 9) < 9) begin
                f = rule_pool[$urandom_range(0, rule_pool.size() - 1)];
                if (op == OP_LOOKUP) begin
                    if (f.sp == '0 && $urandom_range(0, 9) < 7)
                        f.sp = PORT_W'($urandom_range(1, 65535));
                    if (f.dp == '0 && $urandom_range(0, 9) < 7)
                        f.dp = PORT_W'($urandom_range(1, 65535));
                    if ($urandom_range(0, 3) == 0) f.sp = pick_port();
                    if ($urandom_range(0, 3) == 0) f.dp = pick_port();
                end
                if ($urandom_range(0, 1)) begin
                    tmp_addr = f.sa;
                    tmp_port = f.sp;
                    f.sa     = f.da;
                    f.sp     = f.dp;
                    f.da     = tmp_addr;
                    f.dp     = tmp_port;
                end
            end else begin
                f = fresh_flow();
            end
            send_request(op, f, HANDLE_W'($urandom_range(0, 255)));
        end
    endtask

    // Result sink: random ready gaps with back-to-back stretches, and one long
    // hold while requests keep coming, so the block backs up and stalls s_tready.
    initial begin : result_sink
        int wait_cycles;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!hold_done && answered_beats >= HOLD_AT_ANSWER) begin
                hold_done = 1'b1;
                m_tready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            wait_cycles = (answered_beats % 50 < 12) ? 0 : $urandom_range(0, 14);
            if (wait_cycles > 0) begin
                m_tready = 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            table_board.check_answer(m_tuser, m_tdata[7:0], m_tdata[9:8]);
            answered_beats++;
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        table_board  = new();
        addr_pool[0] = '0;
        addr_pool[1] = ADDR_MAX;
        addr_pool[2] = A_ADDR;
        addr_pool[3] = B_ADDR;
        for (int i = 4; i < 8; i++) addr_pool[i] = ADDR_W'($urandom());
        port_pool[0] = 16'd1;
        port_pool[1] = PORT_MAX;
        port_pool[2] = 16'd80;
        port_pool[3] = 16'd443;

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Directed, symmetric keys on (reset value).
        send_request(OP_LOOKUP, '{A_ADDR, 16'd1000, B_ADDR, 16'd80}, 8'h00);   // empty table
        send_request(OP_ADD,    '{A_ADDR, 16'd1000, B_ADDR, 16'd80}, 8'h11);
        send_request(OP_LOOKUP, '{A_ADDR, 16'd1000, B_ADDR, 16'd80}, 8'h00);   // exact
        send_request(OP_LOOKUP, '{B_ADDR, 16'd80, A_ADDR, 16'd1000}, 8'h00);   // reverse dir
        send_request(OP_ADD,    '{B_ADDR, 16'd80, A_ADDR, 16'd1000}, 8'h22);   // duplicate
        send_request(OP_ADD,    '{A_ADDR, 16'd0, B_ADDR, 16'd80}, 8'h33);      // any src port
        send_request(OP_LOOKUP, '{A_ADDR, 16'd5555, B_ADDR, 16'd80}, 8'h00);
        send_request(OP_ADD,    '{A_ADDR, 16'd1000, B_ADDR, 16'd0}, 8'h44);    // any dst port
        send_request(OP_LOOKUP, '{A_ADDR, 16'd1000, B_ADDR, 16'd9999}, 8'h00);
        send_request(OP_ADD,    '{A_ADDR, 16'd0, B_ADDR, 16'd0}, 8'h55);       // both wild
        send_request(OP_LOOKUP, '{A_ADDR, 16'd7, B_ADDR, 16'd7}, 8'h00);
        // src port already 0: second try repeats the first key, third one hits
        send_request(OP_LOOKUP, '{A_ADDR, 16'd0, B_ADDR, 16'd12}, 8'h00);
        // field extremes
        send_request(OP_ADD,    '{32'h0, 16'h0, ADDR_MAX, PORT_MAX}, 8'hFF);
        send_request(OP_LOOKUP, '{ADDR_MAX, PORT_MAX, 32'h0, 16'h0}, 8'h00);
        send_request(OP_ADD,    '{ADDR_MAX, PORT_MAX, ADDR_MAX, PORT_MAX}, 8'h00);
        send_request(OP_LOOKUP, '{ADDR_MAX, PORT_MAX, ADDR_MAX, PORT_MAX}, 8'h00);
        // same address both ends: order decided by port
        send_request(OP_ADD,    '{C_ADDR, 16'd9, C_ADDR, 16'd3}, 8'h66);
        send_request(OP_LOOKUP, '{C_ADDR, 16'd3, C_ADDR, 16'd9}, 8'h00);
        drain_and_settle();

        // Symmetric off: stored rules keep their order, reverse key is new.
        write_symmetric(1'b0);
        send_request(OP_LOOKUP, '{B_ADDR, 16'd80, A_ADDR, 16'd1000}, 8'h00);
        send_request(OP_ADD,    '{B_ADDR, 16'd80, A_ADDR, 16'd1000}, 8'h77);
        send_request(OP_LOOKUP, '{B_ADDR, 16'd80, A_ADDR, 16'd1000}, 8'h00);
        send_request(OP_LOOKUP, '{A_ADDR, 16'd1000, B_ADDR, 16'd80}, 8'h00);
        send_request(OP_LOOKUP, '{C_ADDR, 16'd9, C_ADDR, 16'd3}, 8'h00);
        drain_and_settle();

        // Random phases, setting flipped between them; table fills along the
        // way, so later adds run into the full and duplicate-when-full cases.
        run_random_phase(RANDOM_PER_PHASE);
        drain_and_settle();
        write_symmetric(1'b1);
        run_random_phase(RANDOM_PER_PHASE);
        drain_and_settle();
        write_symmetric(1'b0);
        run_random_phase(RANDOM_PER_PHASE);
        drain_and_settle();
        write_symmetric(1'b1);
        run_random_phase(RANDOM_PER_PHASE);
        drain_and_settle();

        $display("ran %0d request beats across %0d symmetric-mode writes, %0d rules in table",
                 sent_beats, sym_writes, table_board.rules_held());
        $display({"hits exact/any-src/any-dst/both %0d/%0d/%0d/%0d, ",
                  "miss %0d, added %0d, dup %0d, full %0d"},
                 table_board.try_hits[TRY_EXACT], table_board.try_hits[TRY_ANY_SRC],
                 table_board.try_hits[TRY_ANY_DST], table_board.try_hits[TRY_BOTH_ANY],
                 table_board.status_seen[ST_MISS], table_board.status_seen[ST_ADDED],
                 table_board.status_seen[ST_DUP], table_board.status_seen[ST_FULL]);
        if (table_board.errors == 0 && table_board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/frwl_pkg.sv
design/frwl_cell.sv
design/flow_rule_wildcard_lookup.sv
tb/sv/frwl_tb_pkg.sv
tb/sv/flow_rule_wildcard_lookup_tb.sv
